// ===== hdl/tgbs_pkg.sv =====
// Shared types, constants and helper functions of the terrain grid bilinear sampler.
package tgbs_pkg;

  localparam int unsigned MAX_ROWS    = 256;
  localparam int unsigned MAX_COLS    = 256;
  localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
  localparam int unsigned COL_W       = $clog2(MAX_COLS);
  localparam int unsigned GRID_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned GRID_AW     = $clog2(GRID_DEPTH);
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned ELEV_W      = 24;
  localparam int unsigned WGT_W       = 20;
  localparam int unsigned W_FRAC      = 16;
  localparam int unsigned W_ONE       = 2 ** W_FRAC;
  localparam int unsigned W_SAT       = 2 ** 18;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  typedef enum logic [1:0] {
    CMD_WR_LAT  = 2'd0,
    CMD_WR_LNG  = 2'd1,
    CMD_WR_CELL = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_WR_LAT,
    OP_WR_LNG,
    OP_WR_CELL,
    OP_QUERY,
    OP_TOO_SMALL
  } op_e;

  typedef enum logic [1:0] {
    ST_BILINEAR  = 2'd0,
    ST_NEAREST   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FETCH,
    S_DECIDE,
    S_DIV,
    S_MAC,
    S_ROUND,
    S_OUT
  } back_state_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [COORD_W-1:0] axis_coord;
    logic signed [ELEV_W-1:0]  cell_elevation;
    logic signed [COORD_W-1:0] query_lat;
    logic signed [COORD_W-1:0] query_lng;
  } item_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation_out;
    logic [1:0]               query_status;
  } result_t;

  // One classified transaction on its way from the front to the back.
  typedef struct packed {
    op_e                       op;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [ELEV_W-1:0]  elev;
  } entry_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                   input int unsigned lim);
    clamp_count = (32'(c) > lim) ? CNT_W'(lim) : c;
  endfunction

  function automatic logic [COORD_W:0] abs33(input logic signed [COORD_W:0] v);
    abs33 = v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
  endfunction

endpackage

// ===== hdl/tgbs_ifs.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface tgbs_item_if;
  import tgbs_pkg::*;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tgbs_res_if;
  import tgbs_pkg::*;
  logic    valid;
  logic    ready;
  result_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

interface tgbs_cfg_if;
  import tgbs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tgbs_front.sv =====
// Front end: accepts input transactions and classifies them for the back end.
module tgbs_front (
  tgbs_item_if.sink                in_i,
  input  logic [tgbs_pkg::CNT_W-1:0] row_count_i,
  input  logic [tgbs_pkg::CNT_W-1:0] col_count_i,
  input  logic                     clearing_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output tgbs_pkg::entry_t         push_data_o
);
  import tgbs_pkg::*;

  logic row_ok, col_ok, keep, too_small;

  assign row_ok    = 32'(in_i.item.row_index) < MAX_ROWS;
  assign col_ok    = 32'(in_i.item.col_index) < MAX_COLS;
  assign too_small = (clamp_count(row_count_i, MAX_ROWS) < CNT_W'(2)) ||
                     (clamp_count(col_count_i, MAX_COLS) < CNT_W'(2));

  always_comb begin
    push_data_o.row  = ROW_W'(in_i.item.row_index);
    push_data_o.col  = COL_W'(in_i.item.col_index);
    push_data_o.a    = in_i.item.axis_coord;
    push_data_o.b    = in_i.item.query_lng;
    push_data_o.elev = in_i.item.cell_elevation;
    push_data_o.op   = OP_QUERY;
    keep             = 1'b1;
    case (cmd_e'(in_i.item.cmd))
      CMD_WR_LAT: begin
        push_data_o.op = OP_WR_LAT;
        keep           = row_ok;
      end
      CMD_WR_LNG: begin
        push_data_o.op = OP_WR_LNG;
        keep           = col_ok;
      end
      CMD_WR_CELL: begin
        push_data_o.op = OP_WR_CELL;
        keep           = row_ok && col_ok;
      end
      CMD_QUERY: begin
        push_data_o.a  = in_i.item.query_lat;
        push_data_o.op = too_small ? OP_TOO_SMALL : OP_QUERY;
      end
      default: keep = 1'b0;
    endcase
  end

  // Out-of-range writes are taken and dropped here.
  assign in_i.ready   = push_ready_i && !clearing_i;
  assign push_valid_o = in_i.valid && in_i.ready && keep;

endmodule

// ===== hdl/tgbs_queue.sv =====
// Short transaction queue between the front end and the back end.
module tgbs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  tgbs_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output tgbs_pkg::entry_t pop_data_o
);
  import tgbs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NUM_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic             do_push, do_pop;

  assign push_ready_o = num_q != NUM_W'(QUEUE_DEPTH);
  assign pop_valid_o  = num_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tgbs_div.sv =====
// Radix-2 restoring divider that yields a saturated Q16 interpolation weight.
module tgbs_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tgbs_pkg::COORD_W:0]    num_i,
  input  logic signed [tgbs_pkg::COORD_W:0]    den_i,
  output logic                                 busy_o,
  output logic signed [tgbs_pkg::WGT_W-1:0]    quot_o
);
  import tgbs_pkg::*;

  localparam int unsigned MAG_W = COORD_W + 1;
  localparam int unsigned DVD_W = MAG_W + W_FRAC;
  localparam int unsigned CNT_DW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q;
  logic [MAG_W-1:0]  dm_q, rem_q;
  logic [WGT_W-1:0]  quo_q;
  logic              ovf_q, neg_q, busy_q;
  logic [CNT_DW-1:0] cnt_q;
  logic [MAG_W:0]    trial;
  logic              ge;
  logic [WGT_W-1:0]  mag;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_DW'(DVD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CNT_DW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {abs33(num_i), W_FRAC'(0)};
      dm_q  <= abs33(den_i);
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[COORD_W] ^ den_i[COORD_W];
    end else if (busy_q) begin
      rem_q <= ge ? MAG_W'(trial - {1'b0, dm_q}) : trial[MAG_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      // Quotient bits above the weight range only mark saturation.
      ovf_q <= ovf_q | quo_q[WGT_W-1];
      quo_q <= {quo_q[WGT_W-2:0], ge};
    end
  end

  assign mag    = (ovf_q || (32'(quo_q) > W_SAT)) ? WGT_W'(W_SAT) : quo_q;
  assign busy_o = busy_q;
  assign quot_o = (dm_q == '0) ? '0 : (neg_q ? -$signed(mag) : $signed(mag));

endmodule

// ===== hdl/tgbs_back.sv =====
// Back end: axis and grid storage, cell search, corner fetch and the interpolation datapath.
module tgbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tgbs_pkg::CNT_W-1:0] row_count_i,
  input  logic [tgbs_pkg::CNT_W-1:0] col_count_i,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  tgbs_pkg::entry_t           pop_data_i,
  output logic                       clearing_o,
  tgbs_res_if.source                 out_o
);
  import tgbs_pkg::*;

  localparam int unsigned ACC_W  = 66;
  localparam int unsigned F_W    = 44;
  localparam int unsigned F_LO_W = 22;
  localparam int unsigned OPA_W  = 25;
  localparam int unsigned PROD_W = OPA_W + WGT_W;

  back_state_e state_q, state_d;

  // Storage.
  logic signed [COORD_W-1:0] lat_mem [MAX_ROWS];
  logic signed [COORD_W-1:0] lng_mem [MAX_COLS];
  logic [ELEV_W:0]           grid_mem [GRID_DEPTH];
  logic signed [COORD_W-1:0] lat_rd_q, lng_rd_q;
  logic [ELEV_W:0]           grid_rd_q;
  logic [ROW_W-1:0]          lat_ra;
  logic [COL_W-1:0]          lng_ra;
  logic [GRID_AW-1:0]        grid_ra, grid_wa, clr_addr_q;
  logic [ELEV_W:0]           grid_wd;
  logic                      grid_we, lat_we, lng_we;

  logic [CNT_W-1:0]          nr, nc;
  logic signed [COORD_W-1:0] lat_q, lng_q, y1_q, y2_q, x1_q, x2_q;
  logic [CNT_W-1:0]          lat_lo_q, lat_hi_q, lng_lo_q, lng_hi_q, lat_mid, lng_mid;
  logic [CNT_W-1:0]          lat_t, lng_t, lat_cell, lng_cell;
  logic                      lat_act, lng_act;
  logic [ROW_W-1:0]          row_i_q;
  logic [COL_W-1:0]          col_j_q;
  logic [2:0]                fcnt_q;
  logic [ELEV_W:0]           corner_q [4];
  logic                      all_valid, near_r, near_c;
  logic [1:0]                near_sel;

  logic                      div_start, bx_busy, by_busy;
  logic signed [WGT_W-1:0]   tx, ty, wx0_q, wx1_q, wy0_q, wy1_q;

  logic [2:0]                mac_cnt_q;
  logic                      mac_ph_q;
  logic signed [OPA_W-1:0]   mac_a;
  logic signed [WGT_W-1:0]   mac_b;
  logic                      mac_sh;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, mac_sum, rnd;
  logic signed [F_W-1:0]     f1_q, f2_q;
  logic signed [ACC_W-33:0]  e_full;

  logic signed [ELEV_W-1:0]  pend_elev_q;
  status_e                   pend_st_q;
  result_t                   res_q;
  logic                      res_valid_q, res_load;

  assign nr = clamp_count(row_count_i, MAX_ROWS);
  assign nc = clamp_count(col_count_i, MAX_COLS);

  // Binary search bookkeeping; cell index is lower bound minus one, clamped.
  assign lat_mid  = CNT_W'((10'(lat_lo_q) + 10'(lat_hi_q)) >> 1);
  assign lng_mid  = CNT_W'((10'(lng_lo_q) + 10'(lng_hi_q)) >> 1);
  assign lat_act  = lat_lo_q < lat_hi_q;
  assign lng_act  = lng_lo_q < lng_hi_q;
  assign lat_t    = (lat_lo_q != '0) ? lat_lo_q - 1'b1 : '0;
  assign lng_t    = (lng_lo_q != '0) ? lng_lo_q - 1'b1 : '0;
  assign lat_cell = (lat_t > nr - CNT_W'(2)) ? nr - CNT_W'(2) : lat_t;
  assign lng_cell = (lng_t > nc - CNT_W'(2)) ? nc - CNT_W'(2) : lng_t;

  always_comb begin
    lat_ra  = ROW_W'(lat_mid);
    lng_ra  = COL_W'(lng_mid);
    if (state_q == S_FETCH) begin
      lat_ra = (fcnt_q == 3'd0) ? row_i_q : row_i_q + 1'b1;
      lng_ra = (fcnt_q == 3'd0) ? col_j_q : col_j_q + 1'b1;
    end
    grid_ra = GRID_AW'((32'(row_i_q) + 32'(fcnt_q[1])) * MAX_COLS +
                       32'(col_j_q) + 32'(fcnt_q[0]));
  end

  assign lat_we  = (state_q == S_IDLE) && pop_valid_i && (pop_data_i.op == OP_WR_LAT);
  assign lng_we  = (state_q == S_IDLE) && pop_valid_i && (pop_data_i.op == OP_WR_LNG);
  assign grid_we = (state_q == S_CLEAR) ||
                   ((state_q == S_IDLE) && pop_valid_i && (pop_data_i.op == OP_WR_CELL));
  assign grid_wa = (state_q == S_CLEAR) ? clr_addr_q :
                   GRID_AW'(32'(pop_data_i.row) * MAX_COLS + 32'(pop_data_i.col));
  assign grid_wd = (state_q == S_CLEAR) ? '0 : {1'b1, pop_data_i.elev};

  always_ff @(posedge clk_i) begin
    if (lat_we) begin
      lat_mem[pop_data_i.row] <= pop_data_i.a;
    end
    if (lng_we) begin
      lng_mem[pop_data_i.col] <= pop_data_i.a;
    end
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    lat_rd_q  <= lat_mem[lat_ra];
    lng_rd_q  <= lng_mem[lng_ra];
    grid_rd_q <= grid_mem[grid_ra];
  end

  // Nearest corner for the fallback path; ties go to the lower index.
  assign all_valid = corner_q[0][ELEV_W] & corner_q[1][ELEV_W] &
                     corner_q[2][ELEV_W] & corner_q[3][ELEV_W];
  assign near_r    = abs33(33'(lat_q) - 33'(y1_q)) > abs33(33'(y2_q) - 33'(lat_q));
  assign near_c    = abs33(33'(lng_q) - 33'(x1_q)) > abs33(33'(x2_q) - 33'(lng_q));
  assign near_sel  = {near_r, near_c};

  tgbs_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (33'(lng_q) - 33'(x1_q)),
    .den_i   (33'(x2_q) - 33'(x1_q)),
    .busy_o  (bx_busy),
    .quot_o  (tx)
  );

  tgbs_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (33'(lat_q) - 33'(y1_q)),
    .den_i   (33'(y2_q) - 33'(y1_q)),
    .busy_o  (by_busy),
    .quot_o  (ty)
  );

  // Row blends use the elevations directly; the column blend splits each
  // row result into a low unsigned and a high signed part.
  always_comb begin
    mac_sh = 1'b0;
    case (mac_cnt_q)
      3'd0: begin
        mac_a = OPA_W'($signed(corner_q[0][ELEV_W-1:0]));
        mac_b = wx0_q;
      end
      3'd1: begin
        mac_a = OPA_W'($signed(corner_q[1][ELEV_W-1:0]));
        mac_b = wx1_q;
      end
      3'd2: begin
        mac_a = OPA_W'($signed(corner_q[2][ELEV_W-1:0]));
        mac_b = wx0_q;
      end
      3'd3: begin
        mac_a = OPA_W'($signed(corner_q[3][ELEV_W-1:0]));
        mac_b = wx1_q;
      end
      3'd4: begin
        mac_a = $signed({3'b000, f1_q[F_LO_W-1:0]});
        mac_b = wy0_q;
      end
      3'd5: begin
        mac_a  = OPA_W'($signed(f1_q[F_W-1:F_LO_W]));
        mac_b  = wy0_q;
        mac_sh = 1'b1;
      end
      3'd6: begin
        mac_a = $signed({3'b000, f2_q[F_LO_W-1:0]});
        mac_b = wy1_q;
      end
      default: begin
        mac_a  = OPA_W'($signed(f2_q[F_W-1:F_LO_W]));
        mac_b  = wy1_q;
        mac_sh = 1'b1;
      end
    endcase
  end

  assign mac_sum = acc_q + (mac_sh ? (ACC_W'(prod_q) <<< F_LO_W) : ACC_W'(prod_q));
  assign rnd     = acc_q + (ACC_W'(1) <<< 31);
  assign e_full  = rnd[ACC_W-1:32];

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    div_start   = 1'b0;
    res_load    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == GRID_AW'(GRID_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_ready_o = 1'b1;
          case (pop_data_i.op)
            OP_QUERY:     state_d = S_SRCH_RD;
            OP_TOO_SMALL: state_d = S_OUT;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        state_d = (lat_act || lng_act) ? S_SRCH_CMP : S_FETCH;
      end
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_FETCH: begin
        if (fcnt_q == 3'd4) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (all_valid) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (!bx_busy && !by_busy) state_d = S_MAC;
      end
      S_MAC: begin
        if (mac_ph_q && (mac_cnt_q == 3'd7)) state_d = S_ROUND;
      end
      S_ROUND: state_d = S_OUT;
      S_OUT: begin
        if (!res_valid_q || out_o.ready) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        lat_q       <= pop_data_i.a;
        lng_q       <= pop_data_i.b;
        lat_lo_q    <= '0;
        lat_hi_q    <= nr;
        lng_lo_q    <= '0;
        lng_hi_q    <= nc;
        pend_elev_q <= '0;
        pend_st_q   <= ST_TOO_SMALL;
      end
      S_SRCH_RD: begin
        row_i_q <= ROW_W'(lat_cell);
        col_j_q <= COL_W'(lng_cell);
        fcnt_q  <= '0;
      end
      S_SRCH_CMP: begin
        if (lat_act) begin
          if (lat_rd_q < lat_q) lat_lo_q <= lat_mid + 1'b1;
          else lat_hi_q <= lat_mid;
        end
        if (lng_act) begin
          if (lng_rd_q < lng_q) lng_lo_q <= lng_mid + 1'b1;
          else lng_hi_q <= lng_mid;
        end
      end
      S_FETCH: begin
        fcnt_q <= fcnt_q + 1'b1;
        if (fcnt_q == 3'd1) begin
          y1_q <= lat_rd_q;
          x1_q <= lng_rd_q;
        end
        if (fcnt_q == 3'd2) begin
          y2_q <= lat_rd_q;
          x2_q <= lng_rd_q;
        end
        if (fcnt_q != 3'd0) begin
          corner_q[2'(fcnt_q - 3'd1)] <= grid_rd_q;
        end
      end
      S_DECIDE: begin
        if (corner_q[near_sel][ELEV_W]) begin
          pend_elev_q <= corner_q[near_sel][ELEV_W-1:0];
          pend_st_q   <= ST_NEAREST;
        end else begin
          pend_elev_q <= '0;
          pend_st_q   <= ST_EMPTY;
        end
      end
      S_DIV: begin
        wx0_q     <= WGT_W'(W_ONE) - tx;
        wx1_q     <= tx;
        wy0_q     <= WGT_W'(W_ONE) - ty;
        wy1_q     <= ty;
        mac_cnt_q <= '0;
        mac_ph_q  <= 1'b0;
        acc_q     <= '0;
      end
      S_MAC: begin
        mac_ph_q <= !mac_ph_q;
        if (!mac_ph_q) begin
          prod_q <= mac_a * mac_b;
        end else begin
          mac_cnt_q <= mac_cnt_q + 1'b1;
          if (mac_cnt_q == 3'd1) begin
            f1_q  <= mac_sum[F_W-1:0];
            acc_q <= '0;
          end else if (mac_cnt_q == 3'd3) begin
            f2_q  <= mac_sum[F_W-1:0];
            acc_q <= '0;
          end else begin
            acc_q <= mac_sum;
          end
        end
      end
      S_ROUND: begin
        pend_st_q <= ST_BILINEAR;
        if (e_full > 34'sd8388607) pend_elev_q <= 24'sh7FFFFF;
        else if (e_full < -34'sd8388608) pend_elev_q <= 24'sh800000;
        else pend_elev_q <= e_full[ELEV_W-1:0];
      end
      S_OUT: begin
        if (res_load) begin
          res_q.elevation_out <= pend_elev_q;
          res_q.query_status  <= pend_st_q;
        end
      end
      default: ;
    endcase
  end

  assign clearing_o  = state_q == S_CLEAR;
  assign out_o.valid = res_valid_q;
  assign out_o.res   = res_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_ready_o) else $error("queue popped during clear");

  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> ((32'(row_i_q) + 2 <= 32'(nr)) && (32'(col_j_q) + 2 <= 32'(nc))))
    else $error("cell index beyond axis");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!bx_busy && !by_busy)) else $error("divider restarted while busy");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && res_valid_q && !out_o.ready) |=> (state_q == S_OUT))
    else $error("result register overwritten");

endmodule

// ===== hdl/terrain_grid_bilinear_sampler.sv =====
// Top level of the terrain grid bilinear sampler.
//
// Channels: in_i takes write-axis, write-cell and query transactions; out_o
// returns one result per query and nothing for writes; cfg_i sets the row and
// column counts and is always ready. Write configuration only while idle.
// After reset the block clears every cell mark, one cell a cycle; in_i is held
// not ready during that pass, cfg_i is still taken. Writes retire in the back
// end's idle state without leaving it. A query whose corners are all valid
// passes through the two parallel binary searches over the axis memories, the
// axis and corner reads, the two parallel bit-serial weight dividers, the
// multiply-accumulate sequence, rounding and the output register. On the
// nearest-corner path the corner reads lead straight to the output register,
// as the too-small path goes there straight from the queue.
// A two-entry queue decouples the front end from the back end, and the output
// register keeps one result; when out_o stalls the back end waits with the
// next result while in_i keeps filling the queue.
module terrain_grid_bilinear_sampler (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgbs_item_if.sink  in_i,
  tgbs_res_if.source out_o,
  tgbs_cfg_if.sink   cfg_i
);
  import tgbs_pkg::*;

  logic [CNT_W-1:0] row_count_q, col_count_q;
  logic             push_valid, push_ready, pop_valid, pop_ready, clearing;
  entry_t           push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROW_COUNT: row_count_q <= cfg_i.data;
        REG_COL_COUNT: col_count_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tgbs_front u_front (
    .in_i         (in_i),
    .row_count_i  (row_count_q),
    .col_count_i  (col_count_q),
    .clearing_i   (clearing),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tgbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tgbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .col_count_i (col_count_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule

// ===== test/terrain_grid_bilinear_sampler_tb.sv =====
// Testbench for the terrain grid bilinear sampler: directed and random transactions checked by a scoreboard.
module terrain_grid_bilinear_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_AT_ITEM = 400;
  localparam int unsigned HOLD_CYCLES = 600;

  class elevation_scoreboard;
    logic signed [COORD_W-1:0] lat_tab[MAX_ROWS];
    logic signed [COORD_W-1:0] lng_tab[MAX_COLS];
    logic signed [ELEV_W-1:0]  elev_tab[GRID_DEPTH];
    bit                        mark_tab[GRID_DEPTH];
    int unsigned               rows_cfg;
    int unsigned               cols_cfg;
    result_t                   expected_q[$];
    int                        errors;
    int                        n_in;

    function new();
      foreach (mark_tab[k]) mark_tab[k] = 1'b0;
      rows_cfg = 0;
      cols_cfg = 0;
      errors = 0;
      n_in = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] d);
      if (idx == REG_ROW_COUNT) rows_cfg = d;
      else if (idx == REG_COL_COUNT) cols_cfg = d;
    endfunction

    // Lower-bound search, one step back, clamped to n-2.
    function int unsigned find_cell(bit lat_side, int unsigned n, longint v);
      int unsigned lo, hi, mid;
      longint av;
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        av = lat_side ? longint'($signed(lat_tab[mid])) : longint'($signed(lng_tab[mid]));
        if (av < v) lo = mid + 1;
        else hi = mid;
      end
      if (lo > 0) lo--;
      if (lo > n - 2) lo = n - 2;
      return lo;
    endfunction

    function longint frac_weight(longint v, longint a, longint b);
      longint t, one, sat;
      one = longint'(W_ONE);
      sat = longint'(W_SAT);
      if (a == b) return 0;
      t = ((v - a) * one) / (b - a);
      if (t > sat) t = sat;
      if (t < -sat) t = -sat;
      return t;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note_item(item_t it);
      int unsigned nr, nc, i, j, ii, jj, k11, kn;
      longint lat, lng, y1, y2, x1, x2, tx, ty, f1, f2, f, e;
      result_t r;
      n_in++;
      case (cmd_e'(it.cmd))
        CMD_WR_LAT: lat_tab[it.row_index] = it.axis_coord;
        CMD_WR_LNG: lng_tab[it.col_index] = it.axis_coord;
        CMD_WR_CELL: begin
          elev_tab[it.row_index * MAX_COLS + it.col_index] = it.cell_elevation;
          mark_tab[it.row_index * MAX_COLS + it.col_index] = 1'b1;
        end
        default: begin
          nr = rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg;
          nc = cols_cfg > MAX_COLS ? MAX_COLS : cols_cfg;
          if (nr < 2 || nc < 2) begin
            r.elevation_out = '0;
            r.query_status = ST_TOO_SMALL;
          end else begin
            lat = $signed(it.query_lat);
            lng = $signed(it.query_lng);
            i = find_cell(1'b1, nr, lat);
            j = find_cell(1'b0, nc, lng);
            y1 = $signed(lat_tab[i]);
            y2 = $signed(lat_tab[i+1]);
            x1 = $signed(lng_tab[j]);
            x2 = $signed(lng_tab[j+1]);
            k11 = i * MAX_COLS + j;
            if (!(mark_tab[k11] && mark_tab[k11+1] && mark_tab[k11+MAX_COLS] &&
                  mark_tab[k11+MAX_COLS+1])) begin
              ii = (mag(lat - y1) <= mag(y2 - lat)) ? i : i + 1;
              jj = (mag(lng - x1) <= mag(x2 - lng)) ? j : j + 1;
              kn = ii * MAX_COLS + jj;
              if (mark_tab[kn]) begin
                r.elevation_out = elev_tab[kn];
                r.query_status = ST_NEAREST;
              end else begin
                r.elevation_out = '0;
                r.query_status = ST_EMPTY;
              end
            end else begin
              tx = frac_weight(lng, x1, x2);
              ty = frac_weight(lat, y1, y2);
              f1 = longint'($signed(elev_tab[k11])) * (W_ONE - tx)
                 + longint'($signed(elev_tab[k11+1])) * tx;
              f2 = longint'($signed(elev_tab[k11+MAX_COLS])) * (W_ONE - tx)
                 + longint'($signed(elev_tab[k11+MAX_COLS+1])) * tx;
              f = f1 * (W_ONE - ty) + f2 * ty + (longint'(1) << 31);
              // Rounding half up is a floor of the biased value.
              e = f >>> 32;
              if (e > 8388607) e = 8388607;
              if (e < -8388608) e = -8388608;
              r.elevation_out = e[ELEV_W-1:0];
              r.query_status = ST_BILINEAR;
            end
          end
          expected_q.insert(expected_q.size(), r);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: elev=%0d status=%0d",
                                   $signed(got.elevation_out), got.query_status);
        return;
      end
      want = expected_q.pop_front();
      if (got.elevation_out !== want.elevation_out || got.query_status !== want.query_status)
      begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected elev=%0d status=%0d, got elev=%0d status=%0d",
                   $signed(want.elevation_out), want.query_status,
                   $signed(got.elevation_out), got.query_status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tgbs_item_if in_if ();
  tgbs_res_if  out_if ();
  tgbs_cfg_if  cfg_if ();

  terrain_grid_bilinear_sampler u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  elevation_scoreboard sb;
  int burst_left;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: changing stall patterns and one long hold-off while the queue fills.
  initial begin : result_sink
    int mode_left, mode, hold_left;
    bit held;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.res);
      if (!held && sb.n_in >= HOLD_AT_ITEM) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (mode == 0) out_if.ready <= 1'b1;
      else if (mode == 1) out_if.ready <= 1'($urandom_range(0, 1));
      else out_if.ready <= ($urandom_range(0, 5) == 0);
    end
  end

  task automatic send_item(item_t it);
    int gap;
    in_if.valid <= 1'b1;
    in_if.item <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(it);
    if (burst_left > 0) burst_left--;
    else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, d);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes have no result to wait for, so after the last expected result a drain wait is added for trailing writes.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t make_item(cmd_e c, int r, int k, longint coord, longint ev,
                                      longint qlat, longint qlng);
    item_t it;
    it.cmd = c;
    it.row_index = r[IDX_W-1:0];
    it.col_index = k[IDX_W-1:0];
    it.axis_coord = coord[COORD_W-1:0];
    it.cell_elevation = ev[ELEV_W-1:0];
    it.query_lat = qlat[COORD_W-1:0];
    it.query_lng = qlng[COORD_W-1:0];
    return it;
  endfunction

  // Unused fields of every transaction carry random bits.
  function automatic item_t noisy(cmd_e c, int r, int k, longint coord, longint ev,
                                  longint qlat, longint qlng);
    item_t it;
    it = make_item(c, r, k, coord, ev, qlat, qlng);
    if (c != CMD_WR_LAT && c != CMD_WR_LNG) it.axis_coord = $urandom;
    if (c != CMD_WR_CELL) it.cell_elevation = ELEV_W'($urandom);
    if (c != CMD_QUERY) begin
      it.query_lat = $urandom;
      it.query_lng = $urandom;
    end
    if (c == CMD_WR_LNG || c == CMD_QUERY) it.row_index = IDX_W'($urandom);
    if (c == CMD_WR_LAT || c == CMD_QUERY) it.col_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic longint rand_elev();
    case ($urandom_range(0, 5))
      0: return 8388607;
      1: return -8388608;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return longint'($signed($urandom)) >>> 8;
    endcase
  endfunction

  task automatic write_axis(bit lat_side, int n, bit sorted);
    longint cur, step;
    cur = longint'($signed($urandom)) >>> ($urandom_range(1, 4));
    for (int k = 0; k < n; k++) begin
      if (!sorted) cur = longint'($signed($urandom));
      else if (k > 0) begin
        step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 24);
        cur = cur + step;
        if (cur > 2147483647) cur = 2147483647;
      end
      send_item(noisy(lat_side ? CMD_WR_LAT : CMD_WR_LNG, k, k, cur, 0, 0, 0));
    end
  endtask

  function automatic longint pick_coord(bit lat_side, int n);
    longint lo, hi, span, v;
    lo = lat_side ? $signed(sb.lat_tab[0]) : $signed(sb.lng_tab[0]);
    hi = lat_side ? $signed(sb.lat_tab[n-1]) : $signed(sb.lng_tab[n-1]);
    if (hi < lo) begin
      v = lo; lo = hi; hi = v;
    end
    span = hi - lo + 1;
    case ($urandom_range(0, 7))
      0: v = longint'($signed($urandom));
      1: v = lat_side ? $signed(sb.lat_tab[$urandom_range(0, n-1)])
                      : $signed(sb.lng_tab[$urandom_range(0, n-1)]);
      default: v = lo - span / 4 + longint'({$urandom, $urandom} % (span + span / 2));
    endcase
    if (v > 2147483647) v = 2147483647;
    if (v < -2147483648) v = -2147483648;
    return v;
  endfunction

  task automatic run_phase(int rows, int cols, int nq, bit sorted, int fill_pct, int extra);
    int er, ec;
    wait_idle();
    write_reg(REG_ROW_COUNT, rows[CNT_W-1:0]);
    write_reg(REG_COL_COUNT, cols[CNT_W-1:0]);
    er = rows > MAX_ROWS ? MAX_ROWS : rows;
    ec = cols > MAX_COLS ? MAX_COLS : cols;
    write_axis(1'b1, er, sorted);
    write_axis(1'b0, ec, sorted);
    for (int r = 0; r < er && r < 10; r++)
      for (int c = 0; c < ec && c < 10; c++)
        if ($urandom_range(1, 100) <= fill_pct)
          send_item(noisy(CMD_WR_CELL, r, c, 0, rand_elev(), 0, 0));
    for (int k = 0; k < extra; k++)
      send_item(noisy(CMD_WR_CELL, $urandom_range(0, er - 1), $urandom_range(0, ec - 1), 0,
                      rand_elev(), 0, 0));
    for (int k = 0; k < nq; k++) begin
      // Mixed in: cell writes and axis writes past the entries in use.
      if ($urandom_range(0, 9) == 0)
        send_item(noisy(CMD_WR_CELL, $urandom, $urandom, 0, rand_elev(), 0, 0));
      if ($urandom_range(0, 19) == 0 && er < MAX_ROWS)
        send_item(noisy(CMD_WR_LAT, $urandom_range(er, MAX_ROWS - 1), 0, $urandom, 0, 0, 0));
      if ($urandom_range(0, 19) == 0 && ec < MAX_COLS)
        send_item(noisy(CMD_WR_LNG, 0, $urandom_range(ec, MAX_COLS - 1), $urandom, 0, 0, 0));
      send_item(noisy(CMD_QUERY, 0, 0, 0, 0, pick_coord(1'b1, er), pick_coord(1'b0, ec)));
    end
  endtask

  initial begin : stimulus
    sb = new();
    burst_left = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: grid too small, extreme coordinates and elevations, holes, equal entries.
    write_reg(REG_UNUSED, 9'h1FF);
    write_reg(REG_UNUSED + 2'd1, 9'h1FF);
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    wait_idle();
    write_reg(REG_ROW_COUNT, 9'd1);
    write_reg(REG_COL_COUNT, 9'd256);
    send_item(make_item(CMD_QUERY, 255, 255, -1, -1, -1, -1));
    send_item(make_item(CMD_WR_LAT, 0, 0, -2147483648, 0, 0, 0));
    send_item(make_item(CMD_WR_LAT, 1, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_WR_LAT, 2, 0, 2147483647, 0, 0, 0));
    send_item(make_item(CMD_WR_LNG, 0, 0, -100, 0, 0, 0));
    send_item(make_item(CMD_WR_LNG, 0, 1, -100, 0, 0, 0));
    send_item(make_item(CMD_WR_LNG, 0, 2, 5000, 0, 0, 0));
    send_item(make_item(CMD_WR_CELL, 0, 0, 0, 8388607, 0, 0));
    send_item(make_item(CMD_WR_CELL, 0, 1, 0, -8388608, 0, 0));
    send_item(make_item(CMD_WR_CELL, 1, 0, 0, 8388607, 0, 0));
    send_item(make_item(CMD_WR_CELL, 1, 1, 0, 8388607, 0, 0));
    send_item(make_item(CMD_WR_CELL, 2, 2, 0, -5, 0, 0));
    send_item(make_item(CMD_WR_CELL, 255, 255, 0, -1, 0, 0));
    wait_idle();
    write_reg(REG_ROW_COUNT, 9'd3);
    write_reg(REG_COL_COUNT, 9'd3);
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, -2147483648, -2147483648));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, 2147483647, 2147483647));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, -1073741824, -100));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, -2147483648, 2147483647));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, 1073741824, 4000));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, 2147483647, -100));
    send_item(make_item(CMD_QUERY, 0, 0, 0, 0, 1000, 2600));

    // Random phases, with a count past the maximum and an unsorted axis among them.
    run_phase(511, 2, 15, 1'b1, 100, 10);
    run_phase(2, 2, 30, 1'b1, 100, 0);
    run_phase(4, 5, 40, 1'b0, 70, 0);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(2, 9), $urandom_range(2, 9), 45, ($urandom_range(0, 5) != 0),
                ($urandom_range(0, 2) == 0) ? 40 : 95, 0);
    run_phase(0, 7, 10, 1'b1, 50, 0);
    run_phase(6, 1, 10, 1'b1, 50, 0);

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tgbs_pkg.sv
hdl/tgbs_ifs.sv
hdl/tgbs_front.sv
hdl/tgbs_queue.sv
hdl/tgbs_div.sv
hdl/tgbs_back.sv
hdl/terrain_grid_bilinear_sampler.sv
test/terrain_grid_bilinear_sampler_tb.sv
